// ----- design/crtc_pkg.sv -----
// Shared types and constants for the cartridge RTC latch register block.
// No dependencies; used by every module of the block.
`default_nettype none

package crtc_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_LATCH = 2'd3;

    // Register addresses
    localparam logic [7:0] ADDR_SEC    = 8'h08;
    localparam logic [7:0] ADDR_MIN    = 8'h09;
    localparam logic [7:0] ADDR_HOUR   = 8'h0A;
    localparam logic [7:0] ADDR_DAY_LO = 8'h0B;
    localparam logic [7:0] ADDR_DAY_HI = 8'h0C;

    localparam logic [7:0] READ_UNMAPPED = 8'hFF;

    localparam int HALT_BIT_POS  = 6;
    localparam int CARRY_BIT_POS = 7;

    localparam int DAY_BITS      = 9;
    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       latch_level;
    } crtc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       halted;
    } crtc_out_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_READ,
        OP_WRITE,
        OP_LATCH
    } crtc_op_t;

    typedef enum logic [2:0] {
        SEL_SEC,
        SEL_MIN,
        SEL_HOUR,
        SEL_DAY_LO,
        SEL_DAY_HI,
        SEL_NONE
    } crtc_sel_t;

    typedef struct packed {
        crtc_op_t   op;
        crtc_sel_t  sel;
        logic [7:0] data;
        logic       level;
    } crtc_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM_SEC,
        ST_NORM_MIN,
        ST_NORM_HOUR,
        ST_COMMIT
    } crtc_state_t;

endpackage

`default_nettype wire

// ----- design/crtc_front.sv -----
// Front end: accepts input transactions and classifies them into queue items.
// Depends on crtc_pkg.
`default_nettype none

module crtc_front (
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire crtc_pkg::crtc_in_t  s_data,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output crtc_pkg::crtc_item_t     push_item
);

    crtc_pkg::crtc_op_t  op;
    crtc_pkg::crtc_sel_t sel;

    always_comb begin
        case (s_data.command)
            crtc_pkg::CMD_TICK:  op = crtc_pkg::OP_TICK;
            crtc_pkg::CMD_READ:  op = crtc_pkg::OP_READ;
            crtc_pkg::CMD_WRITE: op = crtc_pkg::OP_WRITE;
            default:             op = crtc_pkg::OP_LATCH;
        endcase
    end

    always_comb begin
        case (s_data.reg_addr)
            crtc_pkg::ADDR_SEC:    sel = crtc_pkg::SEL_SEC;
            crtc_pkg::ADDR_MIN:    sel = crtc_pkg::SEL_MIN;
            crtc_pkg::ADDR_HOUR:   sel = crtc_pkg::SEL_HOUR;
            crtc_pkg::ADDR_DAY_LO: sel = crtc_pkg::SEL_DAY_LO;
            crtc_pkg::ADDR_DAY_HI: sel = crtc_pkg::SEL_DAY_HI;
            default:               sel = crtc_pkg::SEL_NONE;
        endcase
    end

    assign push_item.op    = op;
    assign push_item.sel   = sel;
    assign push_item.data  = s_data.write_data;
    assign push_item.level = s_data.latch_level;
    assign push_valid      = s_valid;
    assign s_ready         = push_ready;

endmodule

`default_nettype wire

// ----- design/crtc_queue.sv -----
// Short FIFO of classified items between the front and back ends.
// Depends on crtc_pkg.
`default_nettype none

module crtc_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire crtc_pkg::crtc_item_t  push_item,
    output logic                       pop_valid,
    input  wire logic                  pop,
    output crtc_pkg::crtc_item_t       pop_item
);

    crtc_pkg::crtc_item_t               entry_reg [crtc_pkg::QUEUE_DEPTH];
    logic [crtc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [crtc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [crtc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (count_reg != crtc_pkg::QCNT_W'(crtc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == crtc_pkg::QPTR_W'(crtc_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == crtc_pkg::QPTR_W'(crtc_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/crtc_back.sv -----
// Back end: live and latched clock registers, write normalisation sequencer
// and the registered result stage. Depends on crtc_pkg.
`default_nettype none

module crtc_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire crtc_pkg::crtc_item_t  q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output crtc_pkg::crtc_out_t        m_data
);

    crtc_pkg::crtc_state_t state_reg, state_next;

    logic [5:0]  live_sec_reg, live_sec_next;
    logic [5:0]  live_min_reg, live_min_next;
    logic [4:0]  live_hour_reg, live_hour_next;
    logic [crtc_pkg::DAY_BITS-1:0] live_day_reg, live_day_next;
    logic        carry_reg, carry_next;

    logic [7:0]  lat_sec_reg, lat_sec_next;
    logic [7:0]  lat_min_reg, lat_min_next;
    logic [7:0]  lat_hour_reg, lat_hour_next;
    logic [7:0]  lat_day_lo_reg, lat_day_lo_next;
    logic [7:0]  lat_day_hi_reg, lat_day_hi_next;
    logic        prev_level_reg, prev_level_next;

    // Working copy of the date while a write is normalised
    logic [7:0]  w_sec_reg, w_sec_next;
    logic [8:0]  w_min_reg, w_min_next;
    logic [8:0]  w_hour_reg, w_hour_next;
    logic [10:0] w_day_reg, w_day_next;

    logic                 out_valid_reg, out_valid_next;
    crtc_pkg::crtc_out_t  out_reg, out_next;

    logic        can_issue;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;

    assign can_issue = (state_reg == crtc_pkg::ST_IDLE) && q_valid
                       && (!out_valid_reg || m_ready);
    assign q_pop   = can_issue;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sec_wrap  = (live_sec_reg == 6'(crtc_pkg::SECS_PER_MIN - 1));
    assign min_wrap  = (live_min_reg == 6'(crtc_pkg::MINS_PER_HOUR - 1));
    assign hour_wrap = (live_hour_reg == 5'(crtc_pkg::HOURS_PER_DAY - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crtc_pkg::ST_IDLE: begin
                if (can_issue && q_item.op == crtc_pkg::OP_WRITE
                    && q_item.sel != crtc_pkg::SEL_NONE) begin
                    state_next = crtc_pkg::ST_NORM_SEC;
                end
            end
            crtc_pkg::ST_NORM_SEC: begin
                if (w_sec_reg < 8'(crtc_pkg::SECS_PER_MIN)) begin
                    state_next = crtc_pkg::ST_NORM_MIN;
                end
            end
            crtc_pkg::ST_NORM_MIN: begin
                if (w_min_reg < 9'(crtc_pkg::MINS_PER_HOUR)) begin
                    state_next = crtc_pkg::ST_NORM_HOUR;
                end
            end
            crtc_pkg::ST_NORM_HOUR: begin
                if (w_hour_reg < 9'(crtc_pkg::HOURS_PER_DAY)) begin
                    state_next = crtc_pkg::ST_COMMIT;
                end
            end
            crtc_pkg::ST_COMMIT: state_next = crtc_pkg::ST_IDLE;
            default:             state_next = crtc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        live_sec_next   = live_sec_reg;
        live_min_next   = live_min_reg;
        live_hour_next  = live_hour_reg;
        live_day_next   = live_day_reg;
        carry_next      = carry_reg;
        lat_sec_next    = lat_sec_reg;
        lat_min_next    = lat_min_reg;
        lat_hour_next   = lat_hour_reg;
        lat_day_lo_next = lat_day_lo_reg;
        lat_day_hi_next = lat_day_hi_reg;
        prev_level_next = prev_level_reg;
        w_sec_next      = w_sec_reg;
        w_min_next      = w_min_reg;
        w_hour_next     = w_hour_reg;
        w_day_next      = w_day_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;

        case (state_reg)
            crtc_pkg::ST_IDLE: begin
                if (can_issue) begin
                    out_next.read_data = 8'h00;
                    // Load the live date; a write overrides one field below
                    w_sec_next  = {2'b00, live_sec_reg};
                    w_min_next  = 9'(live_min_reg);
                    w_hour_next = 9'(live_hour_reg);
                    w_day_next  = {1'b0, carry_reg, live_day_reg};
                    case (q_item.op)
                        crtc_pkg::OP_TICK: begin
                            if (!lat_day_hi_reg[crtc_pkg::HALT_BIT_POS]) begin
                                if (!sec_wrap) begin
                                    live_sec_next = live_sec_reg + 1'b1;
                                end else begin
                                    live_sec_next = '0;
                                    if (!min_wrap) begin
                                        live_min_next = live_min_reg + 1'b1;
                                    end else begin
                                        live_min_next = '0;
                                        if (!hour_wrap) begin
                                            live_hour_next = live_hour_reg + 1'b1;
                                        end else begin
                                            live_hour_next = '0;
                                            live_day_next  = live_day_reg + 1'b1;
                                            if (&live_day_reg) begin
                                                carry_next = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        crtc_pkg::OP_READ: begin
                            case (q_item.sel)
                                crtc_pkg::SEL_SEC:    out_next.read_data = lat_sec_reg;
                                crtc_pkg::SEL_MIN:    out_next.read_data = lat_min_reg;
                                crtc_pkg::SEL_HOUR:   out_next.read_data = lat_hour_reg;
                                crtc_pkg::SEL_DAY_LO: out_next.read_data = lat_day_lo_reg;
                                crtc_pkg::SEL_DAY_HI: out_next.read_data = lat_day_hi_reg;
                                default:              out_next.read_data =
                                                          crtc_pkg::READ_UNMAPPED;
                            endcase
                        end
                        crtc_pkg::OP_WRITE: begin
                            case (q_item.sel)
                                crtc_pkg::SEL_SEC: begin
                                    lat_sec_next = q_item.data;
                                    w_sec_next   = q_item.data;
                                end
                                crtc_pkg::SEL_MIN: begin
                                    lat_min_next = q_item.data;
                                    w_min_next   = 9'(q_item.data);
                                end
                                crtc_pkg::SEL_HOUR: begin
                                    lat_hour_next = q_item.data;
                                    w_hour_next   = 9'(q_item.data);
                                end
                                crtc_pkg::SEL_DAY_LO: begin
                                    lat_day_lo_next = q_item.data;
                                    w_day_next = {1'b0, carry_reg,
                                                  live_day_reg[crtc_pkg::DAY_BITS-1],
                                                  q_item.data};
                                end
                                crtc_pkg::SEL_DAY_HI: begin
                                    lat_day_hi_next = q_item.data;
                                    // bit 7 adds 512 days, bit 0 adds 256
                                    w_day_next = {1'b0,
                                                  q_item.data[crtc_pkg::CARRY_BIT_POS],
                                                  q_item.data[0],
                                                  live_day_reg[7:0]};
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                            if (!prev_level_reg && q_item.level) begin
                                lat_sec_next    = 8'(live_sec_reg);
                                lat_min_next    = 8'(live_min_reg);
                                lat_hour_next   = 8'(live_hour_reg);
                                lat_day_lo_next = live_day_reg[7:0];
                                lat_day_hi_next = '0;
                                lat_day_hi_next[crtc_pkg::HALT_BIT_POS] =
                                    lat_day_hi_reg[crtc_pkg::HALT_BIT_POS];
                                lat_day_hi_next[crtc_pkg::CARRY_BIT_POS] = carry_reg;
                                lat_day_hi_next[0] = live_day_reg[crtc_pkg::DAY_BITS-1];
                            end
                            prev_level_next = q_item.level;
                        end
                    endcase
                    out_valid_next  = 1'b1;
                    out_next.halted = lat_day_hi_next[crtc_pkg::HALT_BIT_POS];
                end
            end
            crtc_pkg::ST_NORM_SEC: begin
                if (w_sec_reg >= 8'(crtc_pkg::SECS_PER_MIN)) begin
                    w_sec_next = w_sec_reg - 8'(crtc_pkg::SECS_PER_MIN);
                    w_min_next = w_min_reg + 1'b1;
                end
            end
            crtc_pkg::ST_NORM_MIN: begin
                if (w_min_reg >= 9'(crtc_pkg::MINS_PER_HOUR)) begin
                    w_min_next  = w_min_reg - 9'(crtc_pkg::MINS_PER_HOUR);
                    w_hour_next = w_hour_reg + 1'b1;
                end
            end
            crtc_pkg::ST_NORM_HOUR: begin
                if (w_hour_reg >= 9'(crtc_pkg::HOURS_PER_DAY)) begin
                    w_hour_next = w_hour_reg - 9'(crtc_pkg::HOURS_PER_DAY);
                    w_day_next  = w_day_reg + 1'b1;
                end
            end
            crtc_pkg::ST_COMMIT: begin
                live_sec_next  = w_sec_reg[5:0];
                live_min_next  = w_min_reg[5:0];
                live_hour_next = w_hour_reg[4:0];
                live_day_next  = w_day_reg[crtc_pkg::DAY_BITS-1:0];
                carry_next     = |w_day_reg[10:crtc_pkg::DAY_BITS];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= crtc_pkg::ST_IDLE;
            live_sec_reg   <= '0;
            live_min_reg   <= '0;
            live_hour_reg  <= '0;
            live_day_reg   <= '0;
            carry_reg      <= 1'b0;
            lat_sec_reg    <= '0;
            lat_min_reg    <= '0;
            lat_hour_reg   <= '0;
            lat_day_lo_reg <= '0;
            lat_day_hi_reg <= '0;
            prev_level_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            live_sec_reg   <= live_sec_next;
            live_min_reg   <= live_min_next;
            live_hour_reg  <= live_hour_next;
            live_day_reg   <= live_day_next;
            carry_reg      <= carry_next;
            lat_sec_reg    <= lat_sec_next;
            lat_min_reg    <= lat_min_next;
            lat_hour_reg   <= lat_hour_next;
            lat_day_lo_reg <= lat_day_lo_next;
            lat_day_hi_reg <= lat_day_hi_next;
            prev_level_reg <= prev_level_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_sec_reg  <= w_sec_next;
        w_min_reg  <= w_min_next;
        w_hour_reg <= w_hour_next;
        w_day_reg  <= w_day_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

// ----- design/cartridge_rtc_latch_registers_top.sv -----
// Flow: an accepted transaction waits in the queue entry register, then is loaded into the
// result register once the back end is idle and its output is free. Tick, read, latch and
// unmapped writes leave the back end idle for the next item; a clock register write holds
// the back end for its normalisation sequence, set by the subtract-per-cycle loops on
// seconds, minutes and hours (longest for a large hour byte). Synchronous active-low reset
// clears the live and latched date to zero. Depends on crtc_pkg, crtc_front, crtc_queue and crtc_back.
`default_nettype none

module cartridge_rtc_latch_registers_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire crtc_pkg::crtc_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output crtc_pkg::crtc_out_t       m_data
);

    logic                  push_valid;
    logic                  push_ready;
    crtc_pkg::crtc_item_t  push_item;
    logic                  q_valid;
    logic                  q_pop;
    crtc_pkg::crtc_item_t  q_item;

    crtc_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    crtc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    crtc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
